FILE: rtl/buffer_based_bitrate_select_assert.svh
// Assertion macros shared by the bitrate selector RTL.
`ifndef BUFFER_BASED_BITRATE_SELECT_ASSERT_SVH
`define BUFFER_BASED_BITRATE_SELECT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define BBRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must be followed in the next cycle by a consequence.
`define BBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BBRS_ASSERT(lbl, prop, msg)
`define BBRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/bbrs_pkg.sv
// Types, widths and codes of the buffer-based bitrate selector.
package bbrs_pkg;

  // Candidate capacity of one decision run.
  localparam int MaxFormats = 16;
  localparam int CntW       = $clog2(MaxFormats + 1);
  localparam int IdxW       = $clog2(MaxFormats);

  // Field widths.
  localparam int SizeW    = 28;
  localparam int UtilW    = 24;
  localparam int BufW     = 24;
  localparam int VW       = 24;
  localparam int ChosenW  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int FracW    = 16;

  // Internal arithmetic widths.
  localparam int ScaledW = UtilW + 1;
  localparam int NumW    = 50;
  localparam int HalfW   = NumW / 2;
  localparam int MulAW   = HalfW + 1;
  localparam int MulBW   = SizeW + 1;
  localparam int MulPW   = MulAW + MulBW;
  localparam int PartW   = HalfW + SizeW;
  localparam int AccW    = NumW + SizeW;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgMode       = 2'd0,
    CfgBolaV      = 2'd1,
    CfgUtilOffset = 2'd2
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StScoreMul,
    StScoreSub,
    StMag,
    StCrossALo,
    StCrossAHi,
    StCrossBLo,
    StCrossBHi,
    StCrossBAcc,
    StUpdate,
    StDone
  } state_e;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

endpackage

FILE: rtl/bbrs_if.sv
// Valid/ready channels for candidate beats and decision beats.
interface bbrs_in_if
  import bbrs_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SizeW-1:0]        format_size;
  logic signed [UtilW-1:0] format_utility;
  logic [BufW-1:0]         buffer_level;
  logic                    last_format;

  modport source (output valid, format_size, format_utility, buffer_level, last_format,
                  input ready);
  modport sink (input valid, format_size, format_utility, buffer_level, last_format,
                output ready);
endinterface

interface bbrs_out_if
  import bbrs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ChosenW-1:0] chosen_index;
  logic               used_fallback;
  logic               overflow;

  modport source (output valid, chosen_index, used_fallback, overflow, input ready);
  modport sink (input valid, chosen_index, used_fallback, overflow, output ready);
endinterface

FILE: rtl/bbrs_mul.sv
// Shared signed multiplier with a registered product.
module bbrs_mul
  import bbrs_pkg::*;
(
  input  logic                    clk_i,
  input  mul_req_t                req_i,
  output logic signed [MulPW-1:0] prod_o
);

  logic signed [MulAW-1:0] op_a;
  logic signed [MulBW-1:0] op_b;
  logic signed [MulPW-1:0] prod_d;
  logic signed [MulPW-1:0] prod_q;

  assign op_a = $signed(req_i.a);
  assign op_b = $signed(req_i.b);

  // Full-precision product; both operands fit without loss.
  always_comb begin
    prod_d = MulPW'(op_a) * MulPW'(op_b);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/buffer_based_bitrate_select.sv
// Top level of the buffer-based bitrate selector.
//
// Takes a run of candidate encodings, one beat each, ended by last_format, and returns one
// decision beat per run: the index of the candidate with the highest score
// (bola_v * (utility + utility_offset) - buffer) / size, or in mode 1 the highest-utility
// candidate when that best score is negative. Scores are compared exactly by
// cross-multiplication on one shared 26x29 multiplier. A candidate that is the first of its
// run, or whose score differs in sign from the best score, skips the cross-multiplication;
// a candidate beyond a full run goes straight to the update. The last candidate then hands
// over the decision, and waits while the previous decision still sits unread in the output
// register. The input is not ready while a candidate is in work. A finished decision waits
// in an output register while the next run is taken in. Candidates beyond 16 in a run are
// dropped and flagged. Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i;
// the user must write it only while no run is in flight, which the block itself does not enforce.
`include "buffer_based_bitrate_select_assert.svh"

module buffer_based_bitrate_select
  import bbrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  bbrs_in_if.sink             in_ch,
  bbrs_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic             mode_q;
  logic [VW-1:0]    bola_v_q;
  logic [UtilW-1:0] util_off_q;

  // Current candidate.
  logic [SizeW-1:0]   size_q, size_d;
  logic [ScaledW-1:0] scaled_q, scaled_d;
  logic               last_q, last_d;
  logic               first_q, first_d;
  logic               skip_q, skip_d;
  logic [IdxW-1:0]    cur_idx_q, cur_idx_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [NumW-1:0]    mag_q, mag_d;
  logic [AccW-1:0]    acc_a_q, acc_a_d;
  logic [AccW-1:0]    acc_b_q, acc_b_d;

  // Run state.
  logic [NumW-1:0]    best_num_q, best_num_d;
  logic [NumW-1:0]    best_mag_q, best_mag_d;
  logic [SizeW-1:0]   best_size_q, best_size_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic [ScaledW-1:0] best_util_q, best_util_d;
  logic [IdxW-1:0]    best_uidx_q, best_uidx_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [BufW-1:0]    lbuf_q, lbuf_d;
  logic               ovf_q, ovf_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [ChosenW-1:0] chosen_q, chosen_d;
  logic               fallback_q, fallback_d;
  logic               out_ovf_q, out_ovf_d;

  // Control.
  state_e                  state_q, state_d;
  logic                    in_ready;
  logic                    in_fire;
  logic                    load_out;
  mul_req_t                mul_req;
  logic signed [MulPW-1:0] prod;
  logic [PartW-1:0]        prod_u;
  logic                    signs_differ;
  logic                    score_gt;
  logic                    util_gt;
  logic                    take_fallback;

  assign in_fire      = in_ch.valid && in_ready;
  assign prod_u       = prod[PartW-1:0];
  assign signs_differ = num_q[NumW-1] != best_num_q[NumW-1];

  // Exact ratio compare: a negative pair wins on the smaller cross product.
  always_comb begin
    if (signs_differ) begin
      score_gt = !num_q[NumW-1];
    end else if (num_q[NumW-1]) begin
      score_gt = acc_a_q < acc_b_q;
    end else begin
      score_gt = acc_a_q > acc_b_q;
    end
  end

  assign util_gt       = $signed(scaled_q) > $signed(best_util_q);
  assign take_fallback = mode_q && best_num_q[NumW-1];

  // Shared multiplier.
  bbrs_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      bola_v_q   <= '0;
      util_off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMode:       mode_q     <= cfg_data_i[0];
        CfgBolaV:      bola_v_q   <= cfg_data_i[VW-1:0];
        CfgUtilOffset: util_off_q <= cfg_data_i[UtilW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_ch.valid) begin
          state_d = (cnt_q >= CntW'(MaxFormats)) ? StUpdate : StScoreMul;
        end
      end
      StScoreMul:  state_d = StScoreSub;
      StScoreSub:  state_d = StMag;
      StMag:       state_d = (first_q || signs_differ) ? StUpdate : StCrossALo;
      StCrossALo:  state_d = StCrossAHi;
      StCrossAHi:  state_d = StCrossBLo;
      StCrossBLo:  state_d = StCrossBHi;
      StCrossBHi:  state_d = StCrossBAcc;
      StCrossBAcc: state_d = StUpdate;
      StUpdate:    state_d = last_q ? StDone : StIdle;
      StDone: begin
        if (!out_valid_q || out_ch.ready) begin
          state_d = StIdle;
        end
      end
      default:     state_d = StIdle;
    endcase
  end

  // Sequencer outputs: input ready, multiplier operands, output load.
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state_q)
      StIdle:     in_ready = 1'b1;
      StScoreMul: begin
        mul_req.a = MulAW'(bola_v_q);
        mul_req.b = {{(MulBW-ScaledW){scaled_q[ScaledW-1]}}, scaled_q};
      end
      StCrossALo: begin
        mul_req.a = MulAW'(mag_q[HalfW-1:0]);
        mul_req.b = MulBW'(best_size_q);
      end
      StCrossAHi: begin
        mul_req.a = MulAW'(mag_q[NumW-1:HalfW]);
        mul_req.b = MulBW'(best_size_q);
      end
      StCrossBLo: begin
        mul_req.a = MulAW'(best_mag_q[HalfW-1:0]);
        mul_req.b = MulBW'(size_q);
      end
      StCrossBHi: begin
        mul_req.a = MulAW'(best_mag_q[NumW-1:HalfW]);
        mul_req.b = MulBW'(size_q);
      end
      StDone:     load_out = !out_valid_q || out_ch.ready;
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    size_d      = size_q;
    scaled_d    = scaled_q;
    last_d      = last_q;
    first_d     = first_q;
    skip_d      = skip_q;
    cur_idx_d   = cur_idx_q;
    num_d       = num_q;
    mag_d       = mag_q;
    acc_a_d     = acc_a_q;
    acc_b_d     = acc_b_q;
    best_num_d  = best_num_q;
    best_mag_d  = best_mag_q;
    best_size_d = best_size_q;
    best_idx_d  = best_idx_q;
    best_util_d = best_util_q;
    best_uidx_d = best_uidx_q;
    cnt_d       = cnt_q;
    lbuf_d      = lbuf_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    chosen_d    = chosen_q;
    fallback_d  = fallback_q;
    out_ovf_d   = out_ovf_q;

    // Capture a candidate beat; a zero size counts as one byte.
    if (in_fire) begin
      size_d    = (in_ch.format_size == '0) ? SizeW'(1) : in_ch.format_size;
      scaled_d  = {in_ch.format_utility[UtilW-1], in_ch.format_utility}
                + {util_off_q[UtilW-1], util_off_q};
      last_d    = in_ch.last_format;
      first_d   = cnt_q == '0;
      skip_d    = cnt_q >= CntW'(MaxFormats);
      cur_idx_d = cnt_q[IdxW-1:0];
      if (cnt_q == '0) begin
        lbuf_d = in_ch.buffer_level;
      end
    end

    unique case (state_q)
      // Numerator: weighted utility in Q34.16 less the buffer moved to Q24.16.
      StScoreSub: num_d = NumW'(prod) - NumW'({lbuf_q, {FracW{1'b0}}});
      StMag:      mag_d = num_q[NumW-1] ? NumW'(0) - num_q : num_q;
      // Cross products built from two half-width partial products each.
      StCrossAHi:  acc_a_d = AccW'(prod_u);
      StCrossBLo:  acc_a_d = acc_a_q + (AccW'(prod_u) << HalfW);
      StCrossBHi:  acc_b_d = AccW'(prod_u);
      StCrossBAcc: acc_b_d = acc_b_q + (AccW'(prod_u) << HalfW);
      StUpdate: begin
        if (skip_q) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_q + CntW'(1);
          if (first_q || score_gt) begin
            best_num_d  = num_q;
            best_mag_d  = mag_q;
            best_size_d = size_q;
            best_idx_d  = cur_idx_q;
          end
          if (first_q || util_gt) begin
            best_util_d = scaled_q;
            best_uidx_d = cur_idx_q;
          end
        end
      end
      StDone: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          chosen_d    = take_fallback ? ChosenW'(best_uidx_q) : ChosenW'(best_idx_q);
          fallback_d  = take_fallback;
          out_ovf_d   = ovf_q;
          // Clear the run for the next decision.
          best_num_d  = '0;
          best_mag_d  = '0;
          best_size_d = SizeW'(1);
          best_idx_d  = '0;
          best_util_d = '0;
          best_uidx_d = '0;
          cnt_d       = '0;
          lbuf_d      = '0;
          ovf_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control and run state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      best_num_q  <= '0;
      best_mag_q  <= '0;
      best_size_q <= SizeW'(1);
      best_idx_q  <= '0;
      best_util_q <= '0;
      best_uidx_q <= '0;
      cnt_q       <= '0;
      lbuf_q      <= '0;
      ovf_q       <= 1'b0;
      first_q     <= 1'b0;
      skip_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      best_num_q  <= best_num_d;
      best_mag_q  <= best_mag_d;
      best_size_q <= best_size_d;
      best_idx_q  <= best_idx_d;
      best_util_q <= best_util_d;
      best_uidx_q <= best_uidx_d;
      cnt_q       <= cnt_d;
      lbuf_q      <= lbuf_d;
      ovf_q       <= ovf_d;
      first_q     <= first_d;
      skip_q      <= skip_d;
      last_q      <= last_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    scaled_q   <= scaled_d;
    cur_idx_q  <= cur_idx_d;
    num_q      <= num_d;
    mag_q      <= mag_d;
    acc_a_q    <= acc_a_d;
    acc_b_q    <= acc_b_d;
    chosen_q   <= chosen_d;
    fallback_q <= fallback_d;
    out_ovf_q  <= out_ovf_d;
  end

  // Port drive.
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_q;
  assign out_ch.chosen_index = chosen_q;
  assign out_ch.used_fallback = fallback_q;
  assign out_ch.overflow     = out_ovf_q;

  // Checks on the sequencer and run state.
  `BBRS_ASSERT(a_cnt_range, cnt_q <= CntW'(MaxFormats), "candidate count beyond capacity")
  `BBRS_ASSERT(a_size_nonzero, best_size_q != '0, "best score size is zero")
  `BBRS_ASSERT_NEXT(a_scored_beat, in_fire && (cnt_q < CntW'(MaxFormats)), state_q == StScoreMul, "scored beat did not start the multiplier")
  `BBRS_ASSERT_NEXT(a_done_clears, load_out, out_valid_q && (cnt_q == '0) && !ovf_q, "decision load did not clear the run")

endmodule
